[hdl/cbm_pkg.sv]
// Shared types, constants and helpers for the cartridge bank mapper.
package cbm_pkg;

  // Bank count and bank number sizes
  localparam int unsigned MaxRomBanks = 64;
  localparam int unsigned BankCountW  = 7;
  localparam int unsigned BankW       = 6;

  // Remainder unit: 8-bit dividend, two quotient bits per cycle
  localparam int unsigned DvdW       = 8;
  localparam int unsigned BitsPerIt  = 2;
  localparam int unsigned RemSteps   = DvdW / BitsPerIt;
  localparam int unsigned RemCntW    = $clog2(RemSteps);

  // Region codes
  localparam logic [1:0] RegionRom     = 2'd0;
  localparam logic [1:0] RegionSysRam  = 2'd1;
  localparam logic [1:0] RegionCartRam = 2'd2;
  localparam logic [1:0] RegionNone    = 2'd3;

  // Configuration register indexes
  localparam logic CfgMapperKind   = 1'b0;
  localparam logic CfgRomBankCount = 1'b1;

  // Request into the remainder unit
  typedef struct packed {
    logic                  start;
    logic [DvdW-1:0]       dividend;
    logic [BankCountW-1:0] divisor;
  } rem_req_t;

  // Status back from the remainder unit
  typedef struct packed {
    logic             done;
    logic [BankW-1:0] rem;
  } rem_rsp_t;

  // Usable bank count: zero acts as one, large counts clip to the maximum
  function automatic logic [BankCountW-1:0] eff_count(input logic [BankCountW-1:0] cnt);
    logic [BankCountW-1:0] res;
    if (cnt == '0) begin
      res = BankCountW'(1);
    end else if (cnt > BankCountW'(MaxRomBanks)) begin
      res = BankCountW'(MaxRomBanks);
    end else begin
      res = cnt;
    end
    return res;
  endfunction

endpackage

[hdl/cartridge_bank_mapper.sv]
// Cartridge bank mapper top level: sequencer, bank state and result register.
//
// Usage: each input word (operation, address, write_data) is a CPU access. It is
// accepted at a clock edge with in_valid_i high and in_stall_o low, and yields
// exactly one result word (region, region_offset, write_strobe, data_out) that is
// taken at an edge with out_valid_o high and out_stall_i low.
// The result is loaded into the output register once the bank-number modulo in
// the shared remainder unit, which retires two dividend bits per cycle, is done;
// a new input is accepted only after that load.
// in_stall_o is high from acceptance until the result is loaded into the
// output register. A result waiting on a stalled receiver does not block the
// next input; that next word waits before its result load until the output
// register has been emptied.
// Configuration: cfg_index_i 0 selects mapper_kind, 1 rom_bank_count; writes
// are always ready; users must issue them only while idle; nothing checks this.
// Reset: mapper_kind 0, rom_bank_count 1, banks 0/1/2, cart RAM disabled,
// bank bit 0, no result pending.
module cartridge_bank_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Access channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  region_o,
  output logic [19:0] region_offset_o,
  output logic        write_strobe_o,
  output logic [7:0]  data_out_o,
  // Configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0] state_q, state_d;

  // Configuration registers
  logic                           kind_q;
  logic [cbm_pkg::BankCountW-1:0] count_q;

  // Bank state
  logic [cbm_pkg::BankW-1:0] slot0_q, slot0_d;
  logic [cbm_pkg::BankW-1:0] slot1_q, slot1_d;
  logic [cbm_pkg::BankW-1:0] slot2_q, slot2_d;
  logic                      ram_en_q, ram_en_d;
  logic                      ram_bank_q, ram_bank_d;

  // Latched access
  logic        op_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  region_q, region_d;
  logic [19:0] offset_q, offset_d;
  logic        strobe_q, strobe_d;
  logic [7:0]  dout_q, dout_d;

  cbm_pkg::rem_req_t rem_req;
  cbm_pkg::rem_rsp_t rem_rsp;

  logic                      in_fire;
  logic                      out_free;
  logic                      finish;
  logic [cbm_pkg::BankW-1:0] read_slot;
  logic [cbm_pkg::BankW-1:0] r;
  logic [19:0]               rom_off;
  logic [19:0]               cart_off;
  logic [19:0]               ram_off;
  logic                      hit_a0000, hit_a4000, hit_a8000;
  logic                      in_cart_win, in_sys_ram;

  assign in_stall_o  = (state_q != StIdle);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign finish      = (state_q == StFin) && out_free;

  // Operand for the modulo: bank of the addressed slot on a read, data on a write
  always_comb begin
    unique case (address_i[15:14])
      2'd0:    read_slot = slot0_q;
      2'd1:    read_slot = slot1_q;
      default: read_slot = slot2_q;
    endcase
    rem_req.start   = in_fire;
    rem_req.divisor = cbm_pkg::eff_count(count_q);
    if (!operation_i) begin
      rem_req.dividend = cbm_pkg::DvdW'(read_slot);
    end else if (kind_q && (address_i == 16'h4000)) begin
      rem_req.dividend = {1'b0, write_data_i[6:0]};
    end else begin
      rem_req.dividend = write_data_i;
    end
  end

  cbm_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_fire) state_d = StRun;
      StRun:   if (rem_rsp.done) state_d = StFin;
      StFin:   if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Offset candidates
  assign r           = rem_rsp.rem;
  assign rom_off     = {r, addr_q[13:0]};
  assign cart_off    = {5'd0, ram_bank_q, addr_q[13:0]};
  assign ram_off     = {7'd0, addr_q[12:0]};
  assign hit_a0000   = (addr_q == 16'h0000);
  assign hit_a4000   = (addr_q == 16'h4000);
  assign hit_a8000   = (addr_q == 16'h8000);
  assign in_cart_win = (addr_q[15:13] == 3'b101);
  assign in_sys_ram  = (addr_q[15:14] == 2'b11);

  // Result and bank-state update at the end of an item
  always_comb begin
    slot0_d    = slot0_q;
    slot1_d    = slot1_q;
    slot2_d    = slot2_q;
    ram_en_d   = ram_en_q;
    ram_bank_d = ram_bank_q;
    region_d   = cbm_pkg::RegionNone;
    offset_d   = '0;
    strobe_d   = 1'b0;

    if (!op_q) begin
      // Reads
      if (in_sys_ram) begin
        region_d = cbm_pkg::RegionSysRam;
        offset_d = ram_off;
      end else if (kind_q && in_cart_win && ram_en_q) begin
        region_d = cbm_pkg::RegionCartRam;
        offset_d = ram_off;
      end else if (!kind_q && addr_q[15] && ram_en_q) begin
        region_d = cbm_pkg::RegionCartRam;
        offset_d = cart_off;
      end else begin
        region_d = cbm_pkg::RegionRom;
        offset_d = rom_off;
      end
    end else if (kind_q) begin
      // Writes, alternate mapper
      if (hit_a0000) begin
        slot0_d = r;
      end else if (hit_a4000) begin
        slot1_d  = r;
        ram_en_d = data_q[7];
      end else if (hit_a8000) begin
        slot2_d = r;
      end else if (in_cart_win && ram_en_q) begin
        region_d = cbm_pkg::RegionCartRam;
        offset_d = ram_off;
        strobe_d = 1'b1;
      end else if (in_sys_ram) begin
        region_d = cbm_pkg::RegionSysRam;
        offset_d = ram_off;
        strobe_d = 1'b1;
      end
    end else begin
      // Writes, standard mapper
      if (in_sys_ram) begin
        region_d = cbm_pkg::RegionSysRam;
        offset_d = ram_off;
        strobe_d = 1'b1;
        // Control registers at the top four bytes
        if (addr_q[15:2] == 14'h3FFF) begin
          unique case (addr_q[1:0])
            2'd0: begin
              ram_en_d   = data_q[3];
              ram_bank_d = data_q[2];
            end
            2'd1:    slot0_d = r;
            2'd2:    slot1_d = r;
            default: slot2_d = r;
          endcase
        end
      end else if (addr_q[15] && ram_en_q) begin
        region_d = cbm_pkg::RegionCartRam;
        offset_d = cart_off;
        strobe_d = 1'b1;
      end
    end
    dout_d = strobe_d ? data_q : 8'd0;

    // Output valid flag
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      kind_q      <= 1'b0;
      count_q     <= cbm_pkg::BankCountW'(1);
      slot0_q     <= cbm_pkg::BankW'(0);
      slot1_q     <= cbm_pkg::BankW'(1);
      slot2_q     <= cbm_pkg::BankW'(2);
      ram_en_q    <= 1'b0;
      ram_bank_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          cbm_pkg::CfgMapperKind:   kind_q  <= cfg_data_i[0];
          cbm_pkg::CfgRomBankCount: count_q <= cfg_data_i;
          default:                  kind_q  <= kind_q;
        endcase
      end
      if (finish) begin
        slot0_q    <= slot0_d;
        slot1_q    <= slot1_d;
        slot2_q    <= slot2_d;
        ram_en_q   <= ram_en_d;
        ram_bank_q <= ram_bank_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= operation_i;
      addr_q <= address_i;
      data_q <= write_data_i;
    end
    if (finish) begin
      region_q <= region_d;
      offset_q <= offset_d;
      strobe_q <= strobe_d;
      dout_q   <= dout_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign region_o        = region_q;
  assign region_offset_o = offset_q;
  assign write_strobe_o  = strobe_q;
  assign data_out_o      = dout_q;

endmodule

[hdl/cbm_rem_unit.sv]
// Iterative restoring remainder unit, two dividend bits per cycle.
module cbm_rem_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbm_pkg::rem_req_t req_i,
  output cbm_pkg::rem_rsp_t rsp_o
);

  logic                           busy_q, busy_d;
  logic [cbm_pkg::RemCntW-1:0]    cnt_q, cnt_d;
  logic [cbm_pkg::DvdW-1:0]       dvd_q, dvd_d;
  logic [cbm_pkg::BankCountW-1:0] dvs_q, dvs_d;
  logic [cbm_pkg::BankW-1:0]      rem_q, rem_d;
  logic [cbm_pkg::BankW:0]        part1, part2;
  logic [cbm_pkg::BankW-1:0]      red1, red2;
  logic                           last;

  // Two compare-subtract steps; remainder always stays below divisor (<= 64)
  always_comb begin
    part1 = {rem_q, dvd_q[cbm_pkg::DvdW-1]};
    if (part1 >= dvs_q) begin
      red1 = cbm_pkg::BankW'(part1 - dvs_q);
    end else begin
      red1 = part1[cbm_pkg::BankW-1:0];
    end
    part2 = {red1, dvd_q[cbm_pkg::DvdW-2]};
    if (part2 >= dvs_q) begin
      red2 = cbm_pkg::BankW'(part2 - dvs_q);
    end else begin
      red2 = part2[cbm_pkg::BankW-1:0];
    end
  end

  assign last = (cnt_q == cbm_pkg::RemCntW'(cbm_pkg::RemSteps - 1));

  // Iteration control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << cbm_pkg::BitsPerIt;
      rem_d = red2;
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = busy_q && last;
  assign rsp_o.rem  = rem_q;

endmodule
